FILE: hdl/lbe2_pkg.sv
// lbe2_pkg: shared types and constants for the 2-D Legendre basis evaluator.
// Basis index codes, operation classes, the queued item format and the
// fixed-point constants. No dependencies.
package lbe2_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W = 18;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 20;

    // basis index codes on the request channel
    localparam logic [INDEX_W-1:0] IDX_ZERO    = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] IDX_ONE     = INDEX_W'(1);
    localparam logic [INDEX_W-1:0] IDX_LIN_X   = INDEX_W'(2);
    localparam logic [INDEX_W-1:0] IDX_LIN_Y   = INDEX_W'(3);
    localparam logic [INDEX_W-1:0] IDX_XY      = INDEX_W'(4);
    localparam logic [INDEX_W-1:0] IDX_Q_X     = INDEX_W'(5);
    localparam logic [INDEX_W-1:0] IDX_Q_Y     = INDEX_W'(6);
    localparam logic [INDEX_W-1:0] IDX_QB_X    = INDEX_W'(7);
    localparam logic [INDEX_W-1:0] IDX_QB_Y    = INDEX_W'(8);
    localparam logic [INDEX_W-1:0] IDX_C_X     = INDEX_W'(9);
    localparam logic [INDEX_W-1:0] IDX_C_Y     = INDEX_W'(10);
    localparam logic [INDEX_W-1:0] IDX_CB_X    = INDEX_W'(11);
    localparam logic [INDEX_W-1:0] IDX_CB_Y    = INDEX_W'(12);
    localparam logic [INDEX_W-1:0] IDX_QQ      = INDEX_W'(13);
    localparam logic [INDEX_W-1:0] IDX_QUART_X = INDEX_W'(14);
    localparam logic [INDEX_W-1:0] IDX_QUART_Y = INDEX_W'(15);

    // sqrt constants, 24 fraction bits, round to nearest
    localparam int KONST_W    = 28;
    localparam int KONST_FRAC = 24;
    localparam logic signed [KONST_W-1:0] SQRT3  = KONST_W'(29058991);
    localparam logic signed [KONST_W-1:0] SQRT5  = KONST_W'(37514995);
    localparam logic signed [KONST_W-1:0] SQRT7  = KONST_W'(44388341);
    localparam logic signed [KONST_W-1:0] SQRT15 = KONST_W'(64977878);
    localparam logic signed [KONST_W-1:0] SQRT21 = KONST_W'(76882862);

    localparam int QUEUE_DEPTH = 2;

    // a = primary coordinate, b = the other one
    typedef enum logic [3:0] {
        OP_ZERO,    // 0
        OP_ONE,     // 1
        OP_LIN,     // sqrt3*a
        OP_XY,      // 3*a*b
        OP_Q,       // sqrt5*q(a)
        OP_QB,      // sqrt15*b*q(a)
        OP_C,       // sqrt7*c(a)
        OP_CB,      // sqrt21*c(a)*b
        OP_QQ,      // 5/4*(3a^2-1)*(3b^2-1)
        OP_QUART    // 105/8*a^4-45/4*a^2+9/8
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
    } item_t;

endpackage

FILE: hdl/legendre_basis_eval_2d_core.sv
// legendre_basis_eval_2d_core: orthonormal 2-D Legendre basis, total degree <= 4.
// Path from request accept to out_valid: front register, queue, seven pipeline
// stages and the output register.
// Throughput: one request per cycle; the back pipeline holds as a unit while
// out_valid is high and out_ready low, and the queue absorbs the front end.
// Reset clears only handshake and queue state; no clearing pass.
module legendre_basis_eval_2d_core #(
    parameter int FRAC_BITS = lbe2_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lbe2_pkg::COORD_W-1:0] point_xi,
    input  logic signed [lbe2_pkg::COORD_W-1:0] point_eta,
    input  logic [lbe2_pkg::INDEX_W-1:0]        basis_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lbe2_pkg::VALUE_W-1:0] basis_value
);

    logic            push_valid;
    logic            push_ready;
    lbe2_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    lbe2_pkg::item_t pop_item;

    lbe2_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_xi    (point_xi),
        .point_eta   (point_eta),
        .basis_index (basis_index),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    lbe2_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    lbe2_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .basis_value (basis_value)
    );

endmodule

FILE: hdl/lbe2_front.sv
// lbe2_front: accepts a request, clamps the point to the reference square and
// maps the basis index onto an operation class with coordinate order.
// Depends on lbe2_pkg.
module lbe2_front #(
    parameter int FRAC_BITS = lbe2_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [lbe2_pkg::COORD_W-1:0] point_xi,
    input  logic signed [lbe2_pkg::COORD_W-1:0] point_eta,
    input  logic [lbe2_pkg::INDEX_W-1:0]        basis_index,
    output logic                                push_valid,
    input  logic                                push_ready,
    output lbe2_pkg::item_t                     push_item
);

    localparam int XW = lbe2_pkg::COORD_W;
    localparam longint ONE = 64'sd1 <<< FRAC_BITS;

    function automatic logic signed [XW-1:0] clamp_coord(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        if (longint'(v) > ONE)
        begin
            r = XW'(ONE);
        end
        else if (longint'(v) < -ONE)
        begin
            r = XW'(-ONE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic                      f_valid_reg;
    lbe2_pkg::item_t           f_item_reg;
    lbe2_pkg::item_t           item_next;
    logic signed [XW-1:0]      xc;
    logic signed [XW-1:0]      yc;
    logic                      swap;
    lbe2_pkg::op_t             op;

    always_comb
    begin
        xc = clamp_coord(point_xi);
        yc = clamp_coord(point_eta);

        unique case (basis_index) inside
            lbe2_pkg::IDX_ZERO:
                op = lbe2_pkg::OP_ZERO;
            lbe2_pkg::IDX_ONE:
                op = lbe2_pkg::OP_ONE;
            lbe2_pkg::IDX_LIN_X, lbe2_pkg::IDX_LIN_Y:
                op = lbe2_pkg::OP_LIN;
            lbe2_pkg::IDX_XY:
                op = lbe2_pkg::OP_XY;
            lbe2_pkg::IDX_Q_X, lbe2_pkg::IDX_Q_Y:
                op = lbe2_pkg::OP_Q;
            lbe2_pkg::IDX_QB_X, lbe2_pkg::IDX_QB_Y:
                op = lbe2_pkg::OP_QB;
            lbe2_pkg::IDX_C_X, lbe2_pkg::IDX_C_Y:
                op = lbe2_pkg::OP_C;
            lbe2_pkg::IDX_CB_X, lbe2_pkg::IDX_CB_Y:
                op = lbe2_pkg::OP_CB;
            lbe2_pkg::IDX_QQ:
                op = lbe2_pkg::OP_QQ;
            lbe2_pkg::IDX_QUART_X, lbe2_pkg::IDX_QUART_Y:
                op = lbe2_pkg::OP_QUART;
        endcase

        // eta-primary variants run with the coordinates exchanged
        case (basis_index) inside
            lbe2_pkg::IDX_LIN_Y, lbe2_pkg::IDX_Q_Y, lbe2_pkg::IDX_QB_Y,
            lbe2_pkg::IDX_C_Y, lbe2_pkg::IDX_CB_Y, lbe2_pkg::IDX_QUART_Y:
                swap = 1'b1;
            default:
                swap = 1'b0;
        endcase

        item_next.op = op;
        item_next.a  = swap ? yc : xc;
        item_next.b  = swap ? xc : yc;
    end

    assign in_ready   = !f_valid_reg || push_ready;
    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            f_item_reg <= item_next;
        end
    end

endmodule

FILE: hdl/lbe2_queue.sv
// lbe2_queue: small FIFO of classified requests between front and back ends.
// Depends on lbe2_pkg.
module lbe2_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lbe2_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lbe2_pkg::item_t pop_item
);

    localparam int DEPTH = lbe2_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbe2_pkg::item_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push_fire) - CNT_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/lbe2_back.sv
// lbe2_back: evaluation pipeline, alternating multiply and round/combine stages,
// with saturation into the output register. Stalls as a whole on output backpressure.
// Depends on lbe2_pkg.
module lbe2_back #(
    parameter int FRAC_BITS = lbe2_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  lbe2_pkg::item_t                     pop_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lbe2_pkg::VALUE_W-1:0] basis_value
);

    localparam int XW   = lbe2_pkg::COORD_W;
    localparam int KW   = lbe2_pkg::KONST_W;
    localparam int KF   = lbe2_pkg::KONST_FRAC;
    localparam int VW   = lbe2_pkg::VALUE_W;
    localparam int PW   = FRAC_BITS + 2;          // powers of a coordinate
    localparam int QW   = FRAC_BITS + 3;          // 3*a2 - one
    localparam int CW   = FRAC_BITS + 4;          // 5*a3 - 3*a, rounded products
    localparam int UW   = FRAC_BITS + 3;          // c(a)*b rounded
    localparam int RW   = FRAC_BITS + 5;          // result before saturation
    localparam int ZW   = FRAC_BITS + 9;          // quartic sum
    localparam int TW5  = CW + 3;                 // 5*t
    localparam int SQW  = 2 * XW;
    localparam int LW   = XW + KW;
    localparam int M1W  = PW + XW;
    localparam int M2W  = 2 * PW;
    localparam int M3RW = (QW > KW) ? QW : KW;
    localparam int M3W  = QW + M3RW;
    localparam int NW   = CW + KW;
    localparam int WW   = UW + KW;

    localparam longint ONE    = 64'sd1 <<< FRAC_BITS;
    localparam longint VMAX   = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam longint VMIN   = -VMAX - 64'sd1;
    localparam longint HI_LIM = (5 * ONE > VMAX) ? VMAX : 5 * ONE;
    localparam longint LO_LIM = (-5 * ONE < VMIN) ? VMIN : -5 * ONE;

    logic advance;

    // stage 1: squares and the linear product
    logic                   s1_valid_reg;
    lbe2_pkg::op_t          s1_op_reg;
    logic signed [XW-1:0]   s1_a_reg;
    logic signed [XW-1:0]   s1_b_reg;
    logic signed [SQW-1:0]  s1_aa_reg;
    logic signed [SQW-1:0]  s1_bb_reg;
    logic signed [LW-1:0]   s1_ab_reg;
    logic signed [KW-1:0]   m1_rhs;

    // stage 2: rounded squares, q terms, early results
    logic                   s2_valid_reg;
    lbe2_pkg::op_t          s2_op_reg;
    logic signed [XW-1:0]   s2_a_reg;
    logic signed [XW-1:0]   s2_b_reg;
    logic signed [PW-1:0]   s2_a2_reg;
    logic signed [QW-1:0]   s2_qa_reg;
    logic signed [QW-1:0]   s2_qb_reg;
    logic signed [RW-1:0]   s2_val_reg;
    logic signed [PW-1:0]   s2_a2_next;
    logic signed [PW-1:0]   s2_b2_next;
    logic signed [QW-1:0]   s2_qa_next;
    logic signed [QW-1:0]   s2_qb_next;
    logic signed [RW-1:0]   s2_val_next;

    // stage 3: cube, fourth power, q products
    logic                   s3_valid_reg;
    lbe2_pkg::op_t          s3_op_reg;
    logic signed [XW-1:0]   s3_a_reg;
    logic signed [XW-1:0]   s3_b_reg;
    logic signed [PW-1:0]   s3_a2_reg;
    logic signed [M1W-1:0]  s3_m1_reg;
    logic signed [M2W-1:0]  s3_m2_reg;
    logic signed [M3W-1:0]  s3_m3_reg;
    logic signed [RW-1:0]   s3_val_reg;
    logic signed [M3RW-1:0] m3_rhs;

    // stage 4: rounded powers, c term, quartic partial sum
    logic                   s4_valid_reg;
    lbe2_pkg::op_t          s4_op_reg;
    logic signed [XW-1:0]   s4_b_reg;
    logic signed [CW-1:0]   s4_ca_reg;
    logic signed [CW-1:0]   s4_t_reg;
    logic signed [PW-1:0]   s4_a4_reg;
    logic signed [ZW-1:0]   s4_z_reg;
    logic signed [RW-1:0]   s4_val_reg;
    logic signed [PW-1:0]   s4_a3_next;
    logic signed [PW-1:0]   s4_a4_next;
    logic signed [CW-1:0]   s4_ca_next;
    logic signed [CW-1:0]   s4_t_next;
    logic signed [ZW-1:0]   s4_z_next;
    logic signed [RW-1:0]   s4_val_next;

    // stage 5: constant or coordinate product
    logic                   s5_valid_reg;
    lbe2_pkg::op_t          s5_op_reg;
    logic signed [NW-1:0]   s5_n_reg;
    logic signed [CW-1:0]   s5_t_reg;
    logic signed [PW-1:0]   s5_a4_reg;
    logic signed [ZW-1:0]   s5_z_reg;
    logic signed [RW-1:0]   s5_val_reg;
    logic signed [CW-1:0]   m5_lhs;
    logic signed [KW-1:0]   m5_rhs;

    // stage 6
    logic                   s6_valid_reg;
    lbe2_pkg::op_t          s6_op_reg;
    logic signed [UW-1:0]   s6_u_reg;
    logic signed [RW-1:0]   s6_val_reg;
    logic signed [UW-1:0]   s6_u_next;
    logic signed [RW-1:0]   s6_val_next;

    // stage 7
    logic                   s7_valid_reg;
    lbe2_pkg::op_t          s7_op_reg;
    logic signed [WW-1:0]   s7_w_reg;
    logic signed [RW-1:0]   s7_val_reg;

    // output
    logic                   out_valid_reg;
    logic signed [VW-1:0]   basis_value_reg;
    logic signed [RW-1:0]   fin_val;
    logic signed [VW-1:0]   basis_value_next;

    assign advance     = !out_valid_reg || out_ready;
    assign pop_ready   = advance;
    assign out_valid   = out_valid_reg;
    assign basis_value = basis_value_reg;

    always_comb
    begin
        m1_rhs = (pop_item.op == lbe2_pkg::OP_LIN) ? lbe2_pkg::SQRT3 : KW'(pop_item.b);
    end

    always_comb
    begin
        s2_a2_next = PW'((s1_aa_reg + (SQW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        s2_b2_next = PW'((s1_bb_reg + (SQW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        s2_qa_next = (QW'(s2_a2_next) <<< 1) + QW'(s2_a2_next) - QW'(ONE);
        s2_qb_next = (QW'(s2_b2_next) <<< 1) + QW'(s2_b2_next) - QW'(ONE);
        case (s1_op_reg)
            lbe2_pkg::OP_ONE:
                s2_val_next = RW'(ONE);
            lbe2_pkg::OP_LIN:
                s2_val_next = RW'((s1_ab_reg + (LW'(1) <<< (KF - 1))) >>> KF);
            lbe2_pkg::OP_XY:
                s2_val_next = RW'(((s1_ab_reg <<< 1) + s1_ab_reg
                                   + (LW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            default:
                s2_val_next = '0;
        endcase
    end

    always_comb
    begin
        case (s2_op_reg)
            lbe2_pkg::OP_QQ: m3_rhs = M3RW'(s2_qb_reg);
            lbe2_pkg::OP_QB: m3_rhs = M3RW'(s2_b_reg);
            default:         m3_rhs = M3RW'(lbe2_pkg::SQRT5);
        endcase
    end

    always_comb
    begin
        s4_a3_next = PW'((s3_m1_reg + (M1W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        s4_a4_next = PW'((s3_m2_reg + (M2W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        s4_ca_next = (CW'(s4_a3_next) <<< 2) + CW'(s4_a3_next)
                     - (CW'(s3_a_reg) <<< 1) - CW'(s3_a_reg);
        // 9*one - 90*a2
        s4_z_next  = ZW'(9 * ONE) - ((ZW'(s3_a2_reg) <<< 6) + (ZW'(s3_a2_reg) <<< 4)
                     + (ZW'(s3_a2_reg) <<< 3) + (ZW'(s3_a2_reg) <<< 1));
        s4_val_next = s3_val_reg;
        case (s3_op_reg)
            lbe2_pkg::OP_QB:
                s4_t_next = CW'((s3_m3_reg + (M3W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));
            default:
                s4_t_next = CW'((s3_m3_reg + (M3W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        endcase
        if (s3_op_reg == lbe2_pkg::OP_Q)
        begin
            s4_val_next = RW'((s3_m3_reg + (M3W'(1) <<< KF)) >>> (KF + 1));
        end
    end

    always_comb
    begin
        m5_lhs = (s4_op_reg == lbe2_pkg::OP_QB) ? s4_t_reg : s4_ca_reg;
        case (s4_op_reg)
            lbe2_pkg::OP_C:  m5_rhs = lbe2_pkg::SQRT7;
            lbe2_pkg::OP_QB: m5_rhs = lbe2_pkg::SQRT15;
            default:         m5_rhs = KW'(s4_b_reg);
        endcase
    end

    always_comb
    begin
        s6_u_next   = UW'((s5_n_reg + (NW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));
        s6_val_next = s5_val_reg;
        case (s5_op_reg)
            lbe2_pkg::OP_C:
                s6_val_next = RW'((s5_n_reg + (NW'(1) <<< KF)) >>> (KF + 1));
            lbe2_pkg::OP_QB:
                s6_val_next = RW'((s5_n_reg + (NW'(1) <<< (KF - 1))) >>> KF);
            lbe2_pkg::OP_QQ:
                s6_val_next = RW'(((TW5'(s5_t_reg) <<< 2) + TW5'(s5_t_reg) + TW5'(2)) >>> 2);
            lbe2_pkg::OP_QUART:
                // 105*a4 + (9*one - 90*a2), round off three bits
                s6_val_next = RW'(((ZW'(s5_a4_reg) <<< 6) + (ZW'(s5_a4_reg) <<< 5)
                                   + (ZW'(s5_a4_reg) <<< 3) + ZW'(s5_a4_reg)
                                   + s5_z_reg + ZW'(4)) >>> 3);
            default:
                s6_val_next = s5_val_reg;
        endcase
    end

    always_comb
    begin
        if (s7_op_reg == lbe2_pkg::OP_CB)
        begin
            fin_val = RW'((s7_w_reg + (WW'(1) <<< (KF - 1))) >>> KF);
        end
        else
        begin
            fin_val = s7_val_reg;
        end
        if (longint'(fin_val) > HI_LIM)
        begin
            basis_value_next = VW'(HI_LIM);
        end
        else if (longint'(fin_val) < LO_LIM)
        begin
            basis_value_next = VW'(LO_LIM);
        end
        else
        begin
            basis_value_next = VW'(fin_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg <= pop_item.op;
            s1_a_reg  <= pop_item.a;
            s1_b_reg  <= pop_item.b;
            s1_aa_reg <= pop_item.a * pop_item.a;
            s1_bb_reg <= pop_item.b * pop_item.b;
            s1_ab_reg <= pop_item.a * m1_rhs;

            s2_op_reg  <= s1_op_reg;
            s2_a_reg   <= s1_a_reg;
            s2_b_reg   <= s1_b_reg;
            s2_a2_reg  <= s2_a2_next;
            s2_qa_reg  <= s2_qa_next;
            s2_qb_reg  <= s2_qb_next;
            s2_val_reg <= s2_val_next;

            s3_op_reg  <= s2_op_reg;
            s3_a_reg   <= s2_a_reg;
            s3_b_reg   <= s2_b_reg;
            s3_a2_reg  <= s2_a2_reg;
            s3_m1_reg  <= s2_a2_reg * s2_a_reg;
            s3_m2_reg  <= s2_a2_reg * s2_a2_reg;
            s3_m3_reg  <= s2_qa_reg * m3_rhs;
            s3_val_reg <= s2_val_reg;

            s4_op_reg  <= s3_op_reg;
            s4_b_reg   <= s3_b_reg;
            s4_ca_reg  <= s4_ca_next;
            s4_t_reg   <= s4_t_next;
            s4_a4_reg  <= s4_a4_next;
            s4_z_reg   <= s4_z_next;
            s4_val_reg <= s4_val_next;

            s5_op_reg  <= s4_op_reg;
            s5_n_reg   <= m5_lhs * m5_rhs;
            s5_t_reg   <= s4_t_reg;
            s5_a4_reg  <= s4_a4_reg;
            s5_z_reg   <= s4_z_reg;
            s5_val_reg <= s4_val_reg;

            s6_op_reg  <= s5_op_reg;
            s6_u_reg   <= s6_u_next;
            s6_val_reg <= s6_val_next;

            s7_op_reg  <= s6_op_reg;
            s7_w_reg   <= s6_u_reg * lbe2_pkg::SQRT21;
            s7_val_reg <= s6_val_reg;

            basis_value_reg <= basis_value_next;
        end
    end

endmodule

FILE: bench/tb_legendre_basis_eval_2d_core.sv
// Testbench for legendre_basis_eval_2d_core: directed and random points checked
// against a behavioral fixed-point model of the 15 basis functions.
// Depends on lbe2_pkg and the core RTL.
module tb_legendre_basis_eval_2d_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = lbe2_pkg::COORD_W;
    localparam int INDEX_W    = lbe2_pkg::INDEX_W;
    localparam int VALUE_W    = lbe2_pkg::VALUE_W;
    localparam int FRAC       = lbe2_pkg::FRAC_BITS_DEF;
    localparam int SQRT_FRAC  = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 485;
    localparam int DRAIN_LIMIT = 5000;

    localparam longint K_SQRT3  = 64'sd29058991;
    localparam longint K_SQRT5  = 64'sd37514995;
    localparam longint K_SQRT7  = 64'sd44388341;
    localparam longint K_SQRT15 = 64'sd64977878;
    localparam longint K_SQRT21 = 64'sd76882862;

    localparam logic [INDEX_W-1:0] IDX_ZERO      = lbe2_pkg::IDX_ZERO;
    localparam logic [INDEX_W-1:0] IDX_ONE       = lbe2_pkg::IDX_ONE;
    localparam logic [INDEX_W-1:0] IDX_LIN_XI    = lbe2_pkg::IDX_LIN_X;
    localparam logic [INDEX_W-1:0] IDX_LIN_ETA   = lbe2_pkg::IDX_LIN_Y;
    localparam logic [INDEX_W-1:0] IDX_XI_ETA    = lbe2_pkg::IDX_XY;
    localparam logic [INDEX_W-1:0] IDX_Q_XI      = lbe2_pkg::IDX_Q_X;
    localparam logic [INDEX_W-1:0] IDX_Q_ETA     = lbe2_pkg::IDX_Q_Y;
    localparam logic [INDEX_W-1:0] IDX_ETA_Q_XI  = lbe2_pkg::IDX_QB_X;
    localparam logic [INDEX_W-1:0] IDX_XI_Q_ETA  = lbe2_pkg::IDX_QB_Y;
    localparam logic [INDEX_W-1:0] IDX_C_XI      = lbe2_pkg::IDX_C_X;
    localparam logic [INDEX_W-1:0] IDX_C_ETA     = lbe2_pkg::IDX_C_Y;
    localparam logic [INDEX_W-1:0] IDX_C_XI_ETA  = lbe2_pkg::IDX_CB_X;
    localparam logic [INDEX_W-1:0] IDX_C_ETA_XI  = lbe2_pkg::IDX_CB_Y;
    localparam logic [INDEX_W-1:0] IDX_QQ        = lbe2_pkg::IDX_QQ;
    localparam logic [INDEX_W-1:0] IDX_QUART_XI  = lbe2_pkg::IDX_QUART_X;
    localparam logic [INDEX_W-1:0] IDX_QUART_ETA = lbe2_pkg::IDX_QUART_Y;

    localparam logic signed [COORD_W-1:0] FX_ONE     = 18'sd65536;
    localparam logic signed [COORD_W-1:0] FX_NEG_ONE = -18'sd65536;
    localparam logic signed [COORD_W-1:0] RAW_MAX    = 18'sd131071;
    localparam logic signed [COORD_W-1:0] RAW_MIN    = -18'sd131071 - 18'sd1;

    typedef struct {
        logic signed [COORD_W-1:0] xi;
        logic signed [COORD_W-1:0] eta;
        logic [INDEX_W-1:0]        idx;
        logic signed [VALUE_W-1:0] value;
    } basis_expect_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [COORD_W-1:0]   point_xi = '0;
    logic signed [COORD_W-1:0]   point_eta = '0;
    logic [INDEX_W-1:0]          basis_index = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [VALUE_W-1:0]   basis_value;

    basis_expect_t basis_expect_q[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  tx_offered = 1'b0;
    bit  tx_steady = 1'b0;
    int  tx_burst_left = 0;
    int  rx_hold_left = 0;
    int  rx_mode = 0;
    int  rx_mode_left = 0;
    int  rx_phase = 0;

    legendre_basis_eval_2d_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_xi    (point_xi),
        .point_eta   (point_eta),
        .basis_index (basis_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .basis_value (basis_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // floor((v + half) / 2^s)
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(input logic signed [COORD_W-1:0] raw);
        longint v;
        v = raw;
        if (v > FX_ONE)
            v = FX_ONE;
        if (v < FX_NEG_ONE)
            v = FX_NEG_ONE;
        return v;
    endfunction

    function automatic logic signed [VALUE_W-1:0] legendre_basis_value(
        input logic signed [COORD_W-1:0] xi_raw,
        input logic signed [COORD_W-1:0] eta_raw,
        input logic [INDEX_W-1:0]        idx
    );
        longint one, x, y, x2, x3, x4, y2, y3, y4, qx, qy, cx, cy, r, hi, lo;
        one = 64'sd1 <<< FRAC;
        x = clamp_unit(xi_raw);
        y = clamp_unit(eta_raw);
        x2 = round_shift(x * x, FRAC);
        x3 = round_shift(x2 * x, FRAC);
        x4 = round_shift(x2 * x2, FRAC);
        y2 = round_shift(y * y, FRAC);
        y3 = round_shift(y2 * y, FRAC);
        y4 = round_shift(y2 * y2, FRAC);
        qx = 3 * x2 - one;
        qy = 3 * y2 - one;
        cx = 5 * x3 - 3 * x;
        cy = 5 * y3 - 3 * y;
        case (idx)
            IDX_ONE:       r = one;
            IDX_LIN_XI:    r = round_shift(x * K_SQRT3, SQRT_FRAC);
            IDX_LIN_ETA:   r = round_shift(y * K_SQRT3, SQRT_FRAC);
            IDX_XI_ETA:    r = round_shift(3 * x * y, FRAC);
            IDX_Q_XI:      r = round_shift(qx * K_SQRT5, SQRT_FRAC + 1);
            IDX_Q_ETA:     r = round_shift(qy * K_SQRT5, SQRT_FRAC + 1);
            IDX_ETA_Q_XI:  r = round_shift(round_shift(y * qx, FRAC + 1) * K_SQRT15,
                                           SQRT_FRAC);
            IDX_XI_Q_ETA:  r = round_shift(round_shift(x * qy, FRAC + 1) * K_SQRT15,
                                           SQRT_FRAC);
            IDX_C_XI:      r = round_shift(cx * K_SQRT7, SQRT_FRAC + 1);
            IDX_C_ETA:     r = round_shift(cy * K_SQRT7, SQRT_FRAC + 1);
            IDX_C_XI_ETA:  r = round_shift(round_shift(cx * y, FRAC + 1) * K_SQRT21,
                                           SQRT_FRAC);
            IDX_C_ETA_XI:  r = round_shift(round_shift(cy * x, FRAC + 1) * K_SQRT21,
                                           SQRT_FRAC);
            IDX_QQ:        r = round_shift(5 * round_shift(qx * qy, FRAC), 2);
            IDX_QUART_XI:  r = round_shift(105 * x4 - 90 * x2 + 9 * one, 3);
            IDX_QUART_ETA: r = round_shift(105 * y4 - 90 * y2 + 9 * one, 3);
            default:       r = 0;
        endcase
        hi = 5 * one;
        lo = -5 * one;
        if (hi > 524287)
            hi = 524287;
        if (lo < -524288)
            lo = -524288;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return VALUE_W'(r);
    endfunction

    // mostly inside the square, some exact edges, some raw 18-bit patterns
    function automatic logic signed [COORD_W-1:0] random_coord();
        int pick;
        int v;
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            v = $urandom_range(0, 131072);
            return COORD_W'(v - 65536);
        end
        if (pick < 17)
        begin
            case ($urandom_range(0, 4))
                0: return FX_ONE;
                1: return FX_NEG_ONE;
                2: return '0;
                3: return 18'sd1;
                default: return -18'sd1;
            endcase
        end
        return COORD_W'($urandom());
    endfunction

    // Called at a rising edge; returns when the request is taken or a gap after it ends.
    task automatic send_point(
        input logic signed [COORD_W-1:0] xi,
        input logic signed [COORD_W-1:0] eta,
        input logic [INDEX_W-1:0]        idx
    );
        basis_expect_t e;
        int gap;
        in_valid    <= 1'b1;
        point_xi    <= xi;
        point_eta   <= eta;
        basis_index <= idx;
        tx_offered = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        e.xi = xi;
        e.eta = eta;
        e.idx = idx;
        e.value = legendre_basis_value(xi, eta, idx);
        basis_expect_q.push_back(e);
        if (!tx_steady)
        begin
            tx_burst_left--;
            if (tx_burst_left <= 0)
            begin
                tx_burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                tx_offered = 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    task automatic test_index_zero();
        send_point(FX_ONE, FX_NEG_ONE, IDX_ZERO);
        send_point(RAW_MIN, RAW_MAX, IDX_ZERO);
    endtask

    task automatic test_each_function();
        logic [INDEX_W-1:0] idx;
        for (int k = IDX_ONE; k <= IDX_QUART_ETA; k++)
        begin
            idx = INDEX_W'(k);
            send_point(18'sd49152, -18'sd20000, idx);
        end
    endtask

    // corners hit the saturation limit on the product term; raw values beyond
    // the square must land on its edge
    task automatic test_corners_and_clamp();
        send_point(FX_ONE, FX_ONE, IDX_QQ);
        send_point(FX_NEG_ONE, FX_ONE, IDX_QQ);
        send_point(FX_NEG_ONE, FX_NEG_ONE, IDX_QUART_XI);
        send_point(RAW_MAX, RAW_MIN, IDX_C_XI_ETA);
        send_point(RAW_MIN, RAW_MAX, IDX_C_ETA_XI);
        send_point(RAW_MAX, 18'sd65537, IDX_QUART_ETA);
        send_point(-18'sd65537, RAW_MIN, IDX_XI_ETA);
        send_point(18'sd1, -18'sd1, IDX_LIN_ETA);
    endtask

    // receiver holds off while the sender keeps pushing, filling the pipe
    task automatic test_output_backpressure();
        tx_steady = 1'b1;
        rx_hold_left = 200;
        repeat (40)
            send_point(random_coord(), random_coord(), INDEX_W'($urandom_range(0, 15)));
        tx_steady = 1'b0;
    endtask

    task automatic test_random_points();
        int left;
        int seg;
        left = RANDOM_ITEMS;
        while (left > 0)
        begin
            seg = $urandom_range(20, 80);
            if (seg > left)
                seg = left;
            tx_steady = ($urandom_range(0, 3) == 0);
            repeat (seg)
                send_point(random_coord(), random_coord(), INDEX_W'($urandom_range(0, 15)));
            left -= seg;
        end
        tx_steady = 1'b0;
    endtask

    // receiver: picks a new random mode when the current one runs out; a pending hold wins
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else
        begin
            if (rx_mode_left <= 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(50, 300);
            end
            rx_mode_left--;
            rx_phase = (rx_phase + 1) % 5;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (rx_phase != 2) && (rx_phase != 4);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        basis_expect_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (basis_expect_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: basis_value %0d with no request pending",
                             basis_value);
                mismatch_count++;
            end
            else
            begin
                e = basis_expect_q.pop_front();
                if (basis_value !== e.value)
                begin
                    if (mismatch_count < 10)
                        $display("mismatch: xi %0d eta %0d index %0d: expected %0d got %0d",
                                 e.xi, e.eta, e.idx, e.value, basis_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int waited;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_index_zero();
        test_each_function();
        test_corners_and_clamp();
        test_output_backpressure();
        test_random_points();
        if (tx_offered)
        begin
            in_valid <= 1'b0;
            tx_offered = 1'b0;
        end
        waited = 0;
        while (basis_expect_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (basis_expect_q.size() != 0)
        begin
            $display("%0d results never arrived", basis_expect_q.size());
            mismatch_count++;
        end
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
